// ===== hw/rtl/spet_pkg.sv =====
// Shared types and constants of the spindle encoder tracker.
`default_nettype none

package spet_pkg;

    // Fixed field widths of the event and result words and of the configuration port.
    localparam int TICK_W = 32;
    localparam int AVG_W  = 40;
    localparam int PPR_W  = 16;
    localparam int POS_W  = 16;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Register map (index of each register in the map).
    localparam logic [0:0] REG_PPR = 1'b0;

    // Reset value of the pulses-per-revolution register.
    localparam logic [PPR_W-1:0] PPR_RESET = 16'd700;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/spindle_encoder_tracker_unit.sv =====
// Quadrature encoder position and revolution period tracker, top level.
//
//  Channel   Direction  Handshake                    Payload
//  event     in         i_in_valid / o_in_ready      i_pin_select, i_pin_level, i_tick_us
//  result    out        o_out_valid / i_out_ready    o_counted .. o_zero_time
//  config    in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// An event that does not cross zero is taken and its result word is registered
// at the same edge. A zero crossing starts the restoring divider, one quotient
// bit per cycle, and the next event word is taken only once the divider has
// finished that event.
// Synchronous active-low reset clears all tracking state and loads 700 pulses.
// A stalled result word holds the block: no event is taken until it is read.
`default_nettype none

module spindle_encoder_tracker_unit #(
    parameter int COUNT_WIDTH = 16,
    parameter int FRAC_BITS   = 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Event channel
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire                                 i_pin_select,
    input  wire                                 i_pin_level,
    input  wire  [spet_pkg::TICK_W-1:0]         i_tick_us,
    // Result channel
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic                                o_counted,
    output logic                                o_is_warming,
    output logic                                o_dir_reversed,
    output logic [spet_pkg::POS_W-1:0]          o_position_count,
    output logic                                o_zero_hit,
    output logic [spet_pkg::AVG_W-1:0]          o_avg_interval,
    output logic [spet_pkg::TICK_W-1:0]         o_zero_time,
    // Configuration port
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [spet_pkg::APB_AW-1:0]         paddr,
    input  wire  [spet_pkg::APB_DW-1:0]         pwdata,
    output logic [spet_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    localparam int DIV_BITS = spet_pkg::AVG_W + FRAC_BITS;
    localparam int STEP_W   = $clog2(DIV_BITS);
    localparam int CMP_W    = 33;
    localparam int PPR_W    = spet_pkg::PPR_W;
    localparam int TICK_W   = spet_pkg::TICK_W;
    localparam int AVG_W    = spet_pkg::AVG_W;

    // State registers
    spet_pkg::t_state          r_state,      n_state;
    logic [PPR_W-1:0]          r_ppr,        n_ppr;
    logic                      r_prev_valid, n_prev_valid;
    logic                      r_prev_ch,    n_prev_ch;
    logic                      r_warming,    n_warming;
    logic                      r_level_a,    n_level_a;
    logic                      r_level_b,    n_level_b;
    logic                      r_reversed,   n_reversed;
    logic [COUNT_WIDTH-1:0]    r_pulse,      n_pulse;
    logic [TICK_W-1:0]         r_last_edge,  n_last_edge;
    logic [AVG_W-1:0]          r_sum,        n_sum;
    logic [AVG_W-1:0]          r_avg,        n_avg;
    logic [TICK_W-1:0]         r_zero_time,  n_zero_time;
    logic                      r_out_valid,  n_out_valid;
    logic                      r_counted,    n_counted;
    logic                      r_hit,        n_hit;
    // Divider registers: dividend shifts out while quotient shifts in.
    logic [DIV_BITS-1:0]       r_dq,         n_dq;
    logic [PPR_W-1:0]          r_rem,        n_rem;
    logic [STEP_W-1:0]         r_step,       n_step;

    logic                      in_acc;
    logic                      cfg_wr;
    logic [PPR_W-1:0]          ppr_eff;
    logic                      dup;
    logic                      rise_a;
    logic                      dir_rev;
    logic                      lvl_a_nx;
    logic                      lvl_b_nx;
    logic [COUNT_WIDTH-1:0]    cnt_inc;
    logic [COUNT_WIDTH-1:0]    cnt_dec;
    logic [TICK_W-1:0]         delta;
    logic [AVG_W:0]            sum_add;
    logic [PPR_W:0]            rem_sh;
    logic                      rem_ge;
    logic [DIV_BITS-1:0]       dq_step;

    assign in_acc  = i_in_valid && o_in_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign ppr_eff = (r_ppr == '0) ? PPR_W'(1) : r_ppr;

    // Event decode against the previous channel and the current levels.
    assign dup      = r_prev_valid && (i_pin_select == r_prev_ch);
    assign rise_a   = !i_pin_select && i_pin_level;
    assign lvl_a_nx = i_pin_select ? r_level_a : i_pin_level;
    assign lvl_b_nx = i_pin_select ? i_pin_level : r_level_b;
    always_comb begin
        dir_rev = r_reversed;
        if (rise_a) begin
            if (lvl_b_nx) begin
                dir_rev = 1'b0;
            end
        end else if (i_pin_level) begin
            if (lvl_a_nx) begin
                dir_rev = 1'b1;
            end
        end
    end

    assign cnt_inc = r_pulse + COUNT_WIDTH'(1);
    assign cnt_dec = r_pulse - COUNT_WIDTH'(1);
    assign delta   = i_tick_us - r_last_edge;
    assign sum_add = {1'b0, r_sum} + (AVG_W + 1)'(delta);

    // One restoring division step.
    assign rem_sh  = {r_rem, r_dq[DIV_BITS-1]};
    assign rem_ge  = rem_sh >= {1'b0, ppr_eff};
    assign dq_step = {r_dq[DIV_BITS-2:0], rem_ge};

    // Next-state logic and sequencer.
    always_comb begin
        n_state      = r_state;
        n_ppr        = r_ppr;
        n_prev_valid = r_prev_valid;
        n_prev_ch    = r_prev_ch;
        n_warming    = r_warming;
        n_level_a    = r_level_a;
        n_level_b    = r_level_b;
        n_reversed   = r_reversed;
        n_pulse      = r_pulse;
        n_last_edge  = r_last_edge;
        n_sum        = r_sum;
        n_avg        = r_avg;
        n_zero_time  = r_zero_time;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_counted    = r_counted;
        n_hit        = r_hit;
        n_dq         = r_dq;
        n_rem        = r_rem;
        n_step       = r_step;

        if (cfg_wr && (paddr[2] == spet_pkg::REG_PPR)) begin
            n_ppr = pwdata[PPR_W-1:0];
        end

        case (r_state)
            spet_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_out_valid = 1'b1;
                    n_counted   = 1'b0;
                    n_hit       = 1'b0;
                    if (!dup) begin
                        n_prev_valid = 1'b1;
                        n_prev_ch    = i_pin_select;
                        if (r_warming) begin
                            if (rise_a) begin
                                n_last_edge = i_tick_us;
                                n_warming   = 1'b0;
                            end
                        end else begin
                            n_level_a  = lvl_a_nx;
                            n_level_b  = lvl_b_nx;
                            n_reversed = dir_rev;
                            if (rise_a) begin
                                n_counted   = 1'b1;
                                n_last_edge = i_tick_us;
                                // Position step with wrap at the revolution boundary.
                                if (dir_rev) begin
                                    n_pulse = cnt_inc;
                                    if (CMP_W'(cnt_inc) == CMP_W'(ppr_eff)) begin
                                        n_hit   = 1'b1;
                                        n_pulse = '0;
                                    end
                                end else begin
                                    n_pulse = cnt_dec;
                                    if ((r_pulse == '0) ||
                                        (CMP_W'(cnt_dec) > CMP_W'(ppr_eff))) begin
                                        n_hit   = 1'b1;
                                        n_pulse = COUNT_WIDTH'(ppr_eff - PPR_W'(1));
                                    end
                                end
                                if (n_hit) begin
                                    // Start the divide on the finished revolution.
                                    n_dq        = DIV_BITS'(r_sum) << FRAC_BITS;
                                    n_rem       = '0;
                                    n_step      = STEP_W'(DIV_BITS - 1);
                                    n_sum       = AVG_W'(delta);
                                    n_zero_time = i_tick_us;
                                    n_out_valid = 1'b0;
                                    n_state     = spet_pkg::ST_DIV;
                                end else begin
                                    n_sum = sum_add[AVG_W] ? '1 : sum_add[AVG_W-1:0];
                                end
                            end
                        end
                    end
                end
            end
            spet_pkg::ST_DIV: begin
                n_dq  = dq_step;
                n_rem = rem_ge ? PPR_W'(rem_sh - {1'b0, ppr_eff}) : rem_sh[PPR_W-1:0];
                if (r_step == '0) begin
                    // Last quotient bit: saturate to the result width and publish.
                    n_avg       = ((dq_step >> AVG_W) != '0) ? '1 : dq_step[AVG_W-1:0];
                    n_out_valid = 1'b1;
                    n_state     = spet_pkg::ST_IDLE;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            default: begin
                n_state = spet_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= spet_pkg::ST_IDLE;
            r_ppr        <= spet_pkg::PPR_RESET;
            r_prev_valid <= 1'b0;
            r_prev_ch    <= 1'b0;
            r_warming    <= 1'b1;
            r_level_a    <= 1'b0;
            r_level_b    <= 1'b0;
            r_reversed   <= 1'b0;
            r_pulse      <= '0;
            r_last_edge  <= '0;
            r_sum        <= '0;
            r_avg        <= '0;
            r_zero_time  <= '0;
            r_out_valid  <= 1'b0;
            r_counted    <= 1'b0;
            r_hit        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ppr        <= n_ppr;
            r_prev_valid <= n_prev_valid;
            r_prev_ch    <= n_prev_ch;
            r_warming    <= n_warming;
            r_level_a    <= n_level_a;
            r_level_b    <= n_level_b;
            r_reversed   <= n_reversed;
            r_pulse      <= n_pulse;
            r_last_edge  <= n_last_edge;
            r_sum        <= n_sum;
            r_avg        <= n_avg;
            r_zero_time  <= n_zero_time;
            r_out_valid  <= n_out_valid;
            r_counted    <= n_counted;
            r_hit        <= n_hit;
        end
    end

    // Divider datapath registers.
    always_ff @(posedge i_clk) begin
        r_dq   <= n_dq;
        r_rem  <= n_rem;
        r_step <= n_step;
    end

    // Ports. Tracking state only changes when a new word is taken.
    assign o_in_ready       = (r_state == spet_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid      = r_out_valid;
    assign o_counted        = r_counted;
    assign o_is_warming     = r_warming;
    assign o_dir_reversed   = r_reversed;
    assign o_position_count = spet_pkg::POS_W'(r_pulse);
    assign o_zero_hit       = r_hit;
    assign o_avg_interval   = r_avg;
    assign o_zero_time      = r_zero_time;
    assign pready           = 1'b1;
    assign prdata           = (paddr[2] == spet_pkg::REG_PPR) ?
                              spet_pkg::APB_DW'(r_ppr) : '0;

    // Checks on the sequencer and result word.
    a_div_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spet_pkg::ST_DIV) |-> !o_out_valid)
        else $error("result word valid while the divider runs");

    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_hit) |-> o_counted)
        else $error("zero crossing reported on an uncounted event");

    a_hit_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_hit) |=> (r_state == spet_pkg::ST_DIV))
        else $error("zero crossing did not start the divider");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == spet_pkg::ST_DIV) && (r_step == '0)) |=>
        (o_out_valid && (r_state == spet_pkg::ST_IDLE)))
        else $error("divider finished without publishing a result word");

endmodule

`default_nettype wire
